// ----- rtl/grbq_pkg.sv -----
package grbq_pkg;

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Response status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Width of the configuration register.
  localparam int unsigned CFG_BITS = 8;

  // Width of all generation numbers.
  localparam int unsigned GEN_BITS = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/grbq_req_if.sv -----
interface grbq_req_if #(
  parameter int unsigned WORD_BITS = 64
);
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [WORD_BITS-1:0]                write_data;
  logic [grbq_pkg::GEN_BITS-1:0]       reader_generation;
  logic                                reader_has_generation;

  modport source (
    output valid, cmd, write_data, reader_generation, reader_has_generation,
    input  ready
  );

  modport sink (
    input  valid, cmd, write_data, reader_generation, reader_has_generation,
    output ready
  );
endinterface

// ----- rtl/grbq_rsp_if.sv -----
interface grbq_rsp_if #(
  parameter int unsigned WORD_BITS = 64
);
  logic                          valid;
  logic                          ready;
  logic [WORD_BITS-1:0]          read_data;
  logic [grbq_pkg::GEN_BITS-1:0] next_generation;
  logic                          status;

  modport source (
    output valid, read_data, next_generation, status,
    input  ready
  );

  modport sink (
    input  valid, read_data, next_generation, status,
    output ready
  );
endinterface

// ----- rtl/generation_ring_broadcast_queue_unit.sv -----
// Broadcast ring buffer with one writer and any number of readers. A write
// request stores its word in slot (generation mod depth), advances the 32-bit
// write generation and answers with the new generation. A read request
// carries the reader's own generation (or asks for the current one), and the
// response returns the oldest still-held word the reader has not seen, or the
// newest word again when nothing is new, together with the generation the
// reader should present next time. A read before any write answers with the
// empty status and a zero word. The configuration register sets the ring
// depth; it is rounded up to a power of two and capped at the largest power
// of two not above MAX_DEPTH, takes effect at once and does not clear the
// slots. Write it only while the block is idle. Each request is captured
// when it is accepted, then accesses the memory in the execute step and
// then loads the response register in the load step, which waits until the
// response register is free; no new request is accepted before that load.
// The response register lets the next request be accepted while the
// previous response is still waiting; that next request then holds in its
// load step until the waiting response is taken.
module generation_ring_broadcast_queue_unit #(
  parameter int unsigned MAX_DEPTH = 128,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [grbq_pkg::CFG_BITS-1:0] cfg_wr_data_i,
  grbq_req_if.sink                      req_i,
  grbq_rsp_if.source                    rsp_o
);

  grbq_pkg::cmd_t cmd;
  grbq_pkg::sts_t sts;

  // The controller sequences each request; the datapath holds every register
  // that carries payload or ring state.
  grbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  grbq_dp #(
    .MAX_DEPTH (MAX_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i                       (clk_i),
    .rst_ni                      (rst_ni),
    .cmd_i                       (cmd),
    .sts_o                       (sts),
    .cfg_wr_en_i                 (cfg_wr_en_i),
    .cfg_wr_data_i               (cfg_wr_data_i),
    .req_cmd_i                   (req_i.cmd),
    .req_write_data_i            (req_i.write_data),
    .req_reader_generation_i     (req_i.reader_generation),
    .req_reader_has_generation_i (req_i.reader_has_generation),
    .rsp_ready_i                 (rsp_o.ready),
    .rsp_valid_o                 (rsp_o.valid),
    .rsp_read_data_o             (rsp_o.read_data),
    .rsp_next_generation_o       (rsp_o.next_generation),
    .rsp_status_o                (rsp_o.status)
  );

endmodule

// ----- rtl/grbq_ctrl.sv -----
// Sequencer: take a request, execute it against the ring, then load the
// response register once it is free.
module grbq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  grbq_pkg::sts_t sts_i,
  output grbq_pkg::cmd_t cmd_o
);

  grbq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= grbq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      grbq_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = grbq_pkg::ST_EXEC;
        end
      end
      grbq_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = grbq_pkg::ST_LOAD;
      end
      grbq_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = grbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = grbq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/grbq_dp.sv -----
// Datapath: request registers, slot memory with per-slot valid bits,
// generation arithmetic and the response register.
module grbq_dp #(
  parameter int unsigned MAX_DEPTH = 128,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grbq_pkg::cmd_t                      cmd_i,
  output grbq_pkg::sts_t                      sts_o,
  input  logic                                cfg_wr_en_i,
  input  logic [grbq_pkg::CFG_BITS-1:0]       cfg_wr_data_i,
  input  logic                                req_cmd_i,
  input  logic [WORD_BITS-1:0]                req_write_data_i,
  input  logic [grbq_pkg::GEN_BITS-1:0]       req_reader_generation_i,
  input  logic                                req_reader_has_generation_i,
  input  logic                                rsp_ready_i,
  output logic                                rsp_valid_o,
  output logic [WORD_BITS-1:0]                rsp_read_data_o,
  output logic [grbq_pkg::GEN_BITS-1:0]       rsp_next_generation_o,
  output logic                                rsp_status_o
);

  localparam int unsigned GW     = grbq_pkg::GEN_BITS;
  localparam int unsigned AW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CapLog = $clog2(MAX_DEPTH + 1) - 1;
  localparam int unsigned LW     = (CapLog > 0) ? $clog2(CapLog + 1) : 1;

  // Depth setting, held as log2 of the effective depth.
  logic [LW-1:0] dlog_q;
  logic [3:0]    blen;
  logic [3:0]    dlog_clamped;
  logic [grbq_pkg::CFG_BITS-1:0] cfg_m1;

  always_comb begin
    cfg_m1 = cfg_wr_data_i - grbq_pkg::CFG_BITS'(1);
    blen   = 4'd0;
    if (cfg_wr_data_i > grbq_pkg::CFG_BITS'(1)) begin
      for (int i = 0; i < grbq_pkg::CFG_BITS; i++) begin
        if (cfg_m1[i]) begin
          blen = 4'(i + 1);
        end
      end
    end
    dlog_clamped = (blen > 4'(CapLog)) ? 4'(CapLog) : blen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlog_q <= '0;
    end else if (cfg_wr_en_i) begin
      dlog_q <= LW'(dlog_clamped);
    end
  end

  // Captured request.
  logic                 op_q;
  logic [WORD_BITS-1:0] wdata_q;
  logic [GW-1:0]        rgen_q;
  logic                 rhas_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= req_cmd_i;
      wdata_q <= req_write_data_i;
      rgen_q  <= req_reader_generation_i;
      rhas_q  <= req_reader_has_generation_i;
    end
  end

  // Ring state.
  logic [GW-1:0]        wgen_q;
  logic                 has_data_q;
  logic [MAX_DEPTH-1:0] slot_vld_q;

  // Generation arithmetic for a read.
  logic [GW-1:0] depth;
  logic [AW-1:0] mask;
  logic [GW-1:0] g_req;
  logic [GW-1:0] g_back;
  logic [GW-1:0] g_off;
  logic [GW-1:0] g_sel;
  logic [GW-1:0] wgen_inc;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [GW-1:0] rd_next_gen;
  logic          depth_one;
  logic          do_write;
  logic          do_read;

  always_comb begin
    depth     = GW'(1) << dlog_q;
    mask      = AW'(depth - GW'(1));
    depth_one = (dlog_q == '0);
    wgen_inc  = wgen_q + GW'(1);
    waddr     = wgen_q[AW-1:0] & mask;
    g_req     = rhas_q ? rgen_q : wgen_q;
    g_back    = (g_req == wgen_q) ? (g_req - GW'(1)) : g_req;
    // Held generations are wgen-depth .. wgen-1; the distance back from the
    // newest one tells whether g_back is still in the ring.
    g_off     = wgen_q - GW'(1) - g_back;
    g_sel     = (g_off < depth) ? g_back : (wgen_q - depth);
    if (depth_one) begin
      raddr       = '0;
      rd_next_gen = wgen_q;
    end else begin
      raddr       = g_sel[AW-1:0] & mask;
      rd_next_gen = g_sel + GW'(1);
    end
    if (!has_data_q) begin
      rd_next_gen = g_req;
    end
    do_write = cmd_i.exec && (op_q == grbq_pkg::OP_WRITE);
    do_read  = cmd_i.exec && (op_q == grbq_pkg::OP_READ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wgen_q     <= '0;
      has_data_q <= 1'b0;
      slot_vld_q <= '0;
    end else if (do_write) begin
      wgen_q            <= wgen_inc;
      has_data_q        <= 1'b1;
      slot_vld_q[waddr] <= 1'b1;
    end
  end

  // Slot memory: one write or one read per request, registered read data.
  logic [WORD_BITS-1:0] mem_q [MAX_DEPTH];
  logic [WORD_BITS-1:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[waddr] <= wdata_q;
    end
    if (do_read) begin
      mem_rd_q <= mem_q[raddr];
    end
  end

  // Pending result between execution and response load.
  logic [GW-1:0] pend_gen_q;
  logic          pend_empty_q;
  logic          pend_word_ok_q;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      pend_gen_q     <= wgen_inc;
      pend_empty_q   <= 1'b0;
      pend_word_ok_q <= 1'b0;
    end else if (do_read) begin
      pend_gen_q     <= rd_next_gen;
      pend_empty_q   <= !has_data_q;
      pend_word_ok_q <= has_data_q && slot_vld_q[raddr];
    end
  end

  // Response register.
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] out_data_q;
  logic [GW-1:0]        out_gen_q;
  logic                 out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q   <= pend_word_ok_q ? mem_rd_q : '0;
      out_gen_q    <= pend_gen_q;
      out_status_q <= pend_empty_q ? grbq_pkg::STATUS_EMPTY : grbq_pkg::STATUS_OK;
    end
  end

  assign sts_o.out_free        = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o           = out_valid_q;
  assign rsp_read_data_o       = out_data_q;
  assign rsp_next_generation_o = out_gen_q;
  assign rsp_status_o          = out_status_q;

endmodule
